/* design/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the box mean filter with zero padding.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_SIDE_DEF   = 16;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 1024;
  localparam int SIDE_RST   = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SIDE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] mean_out;
    logic [9:0] out_row;
    logic [9:0] out_column;
    logic       run_last;
    logic       frame_last;
  } out_req_t;

  typedef struct packed {
    logic accept;
    logic next_col;
    logic scan_init;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic cur_last;
    logic scan_last;
    logic div_last;
    logic out_free;
  } ctrl_status_t;

endpackage

/* design/bmf_ram.sv */
// ----------------------------------------------------------------------------
// bmf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/bmf_ctrl.sv */
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: accept, column walk, window scan, divide and result hand-off.
// ----------------------------------------------------------------------------
module bmf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bmf_pkg::ctrl_status_t status,
  output bmf_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FLUSH = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.cur_valid) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else if (status.cur_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.next_col = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cur_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_col = 1'b1;
            state_next   = S_CHECK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/bmf_datapath.sv */
// ----------------------------------------------------------------------------
// bmf_datapath
// Config registers, positions, line store, window accumulator, divider and
// output register.
// ----------------------------------------------------------------------------
module bmf_datapath #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_SIDE   = bmf_pkg::MAX_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [bmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  bmf_pkg::in_req_t                   in_data,
  input  logic                               out_ready,
  input  bmf_pkg::ctrl_cmd_t                 cmd,
  output bmf_pkg::ctrl_status_t              status,
  output logic                               out_valid,
  output bmf_pkg::out_req_t                  out_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SLW    = $clog2(MAX_SIDE);
  localparam int AW     = SLW + CW;
  localparam int DEPTH  = MAX_SIDE << CW;
  localparam int XW_RAW = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_SIDE + 1) + 1;
  localparam int XW     = (XW_RAW > 12) ? XW_RAW : 12;
  localparam int SUM_W  = $clog2(255 * MAX_SIDE * MAX_SIDE + 1);
  localparam int DVW    = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int DCW    = $clog2(SUM_W);
  localparam int W_RST  = (bmf_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bmf_pkg::WIDTH_RST;
  localparam int H_RST  = (bmf_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : bmf_pkg::HEIGHT_RST;
  localparam int S_RST  = (bmf_pkg::SIDE_RST > MAX_SIDE) ? MAX_SIDE : bmf_pkg::SIDE_RST;

  function automatic logic [XW-1:0] clamp(input logic [XW-1:0] v, input logic [XW-1:0] hi);
    logic [XW-1:0] r;
    if (v == '0) begin
      r = XW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [XW-1:0]    width_q, height_q, side_q;
  logic [XW-1:0]    row_position, column_position;
  logic [SLW-1:0]   row_slot;
  logic [XW-1:0]    item_r, cc, last_c, orow, ocol;
  logic [SLW-1:0]   item_slot, rd_slot;
  logic             row_ok;
  logic [SLW-1:0]   i_cnt, j_cnt;
  logic             rd_pend;
  logic [SUM_W-1:0] acc, quo;
  logic [DVW-1:0]   rem;
  logic [DCW-1:0]   div_cnt;

  logic [XW-1:0]    side_m1, cur_r, cur_c, rrow, rcol, slot_base;
  logic [SLW-1:0]   cur_slot;
  logic             wrap, in_image;
  logic [DVW-1:0]   divisor;
  logic [DVW:0]     trial;
  logic [7:0]       rd_data;

  assign side_m1   = side_q - XW'(1);
  assign wrap      = (row_position >= height_q + side_m1) || (column_position >= width_q);
  assign cur_r     = wrap ? '0 : row_position;
  assign cur_c     = wrap ? '0 : column_position;
  assign cur_slot  = wrap ? '0 : row_slot;
  assign rrow      = orow + XW'(i_cnt);
  assign rcol      = ocol + XW'(j_cnt);
  assign in_image  = (rrow < height_q) && (rcol < width_q);
  assign slot_base = XW'(item_slot) + XW'(MAX_SIDE) - side_m1;
  assign divisor   = DVW'(side_q * side_q);
  assign trial     = {rem, quo[SUM_W-1]};

  bmf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (cmd.accept && (cur_r < height_q)),
    .wr_addr (AW'({cur_slot, cur_c[CW-1:0]})),
    .wr_data (in_data.opcode ? 8'd0 : in_data.pixel_in),
    .rd_en   (cmd.scan_step),
    .rd_addr (AW'({rd_slot, rcol[CW-1:0]})),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q         <= XW'(W_RST);
      height_q        <= XW'(H_RST);
      side_q          <= XW'(S_RST);
      row_position    <= '0;
      column_position <= '0;
      row_slot        <= '0;
    end else begin
      if (cmd.accept) begin
        if (cur_c + XW'(1) >= width_q) begin
          column_position <= '0;
          if (cur_r + XW'(1) >= height_q + side_m1) begin
            row_position <= '0;
            row_slot     <= '0;
          end else begin
            row_position <= cur_r + XW'(1);
            row_slot     <= (XW'(cur_slot) == XW'(MAX_SIDE - 1)) ? '0 : cur_slot + SLW'(1);
          end
        end else begin
          column_position <= cur_c + XW'(1);
          row_position    <= cur_r;
          row_slot        <= cur_slot;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          bmf_pkg::CFG_WIDTH: begin
            width_q         <= clamp(XW'(cfg_data), XW'(MAX_WIDTH));
            row_position    <= '0;
            column_position <= '0;
            row_slot        <= '0;
          end
          bmf_pkg::CFG_HEIGHT: begin
            height_q        <= clamp(XW'(cfg_data), XW'(MAX_HEIGHT));
            row_position    <= '0;
            column_position <= '0;
            row_slot        <= '0;
          end
          bmf_pkg::CFG_SIDE: begin
            side_q          <= clamp(XW'(cfg_data[4:0]), XW'(MAX_SIDE));
            row_position    <= '0;
            column_position <= '0;
            row_slot        <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= cur_r;
      item_slot <= cur_slot;
      cc        <= cur_c;
      last_c    <= (cur_c == width_q - XW'(1)) ? (width_q + side_m1 - XW'(1)) : cur_c;
      row_ok    <= (cur_r >= side_m1);
    end else if (cmd.next_col) begin
      cc <= cc + XW'(1);
    end
    if (cmd.scan_init) begin
      orow    <= item_r - side_m1;
      ocol    <= cc - side_m1;
      i_cnt   <= '0;
      j_cnt   <= '0;
      rd_slot <= SLW'((slot_base >= XW'(MAX_SIDE)) ? slot_base - XW'(MAX_SIDE) : slot_base);
    end else if (cmd.scan_step) begin
      if (XW'(j_cnt) == side_m1) begin
        j_cnt   <= '0;
        i_cnt   <= i_cnt + SLW'(1);
        rd_slot <= (XW'(rd_slot) == XW'(MAX_SIDE - 1)) ? '0 : rd_slot + SLW'(1);
      end else begin
        j_cnt <= j_cnt + SLW'(1);
      end
    end
    if (cmd.scan_init) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc + SUM_W'(rd_data);
    end
    if (cmd.div_init) begin
      quo     <= acc;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= DVW'(trial - {1'b0, divisor});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= DVW'(trial);
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_data.mean_out   <= quo[7:0];
      out_data.out_row    <= orow[9:0];
      out_data.out_column <= ocol[9:0];
      out_data.run_last   <= (cc == last_c);
      out_data.frame_last <= (orow == height_q - XW'(1)) && (ocol == width_q - XW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step && in_image;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.cur_valid = row_ok && (cc >= side_m1);
  assign status.cur_last  = (cc == last_c);
  assign status.scan_last = (XW'(i_cnt) == side_m1) && (XW'(j_cnt) == side_m1);
  assign status.div_last  = (div_cnt == DCW'(SUM_W - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

/* design/box_mean_filter_zero_pad_unit.sv */
// sequence: an accept per request, then per result a check, side*side line store
// reads, a flush and a load state, a bit-serial divide of one bit per cycle and
// a hand-off; a skipped column takes only a check
// throughput: one request at a time, the next is taken back in idle after the
// last hand-off or check; a hand-off waits while the output register is held
// reset: synchronous, active high; positions to zero, registers to their defaults
// ----------------------------------------------------------------------------
// box_mean_filter_zero_pad_unit
// Streaming box mean filter with zero padding over a raster pixel stream.
// ----------------------------------------------------------------------------
module box_mean_filter_zero_pad_unit #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_SIDE   = bmf_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bmf_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bmf_pkg::out_req_t               out_data
);

  bmf_pkg::ctrl_cmd_t    cmd;
  bmf_pkg::ctrl_status_t status;

  assign cfg_ready = 1'b1;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SIDE   (MAX_SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_frame_last_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_last |-> out_data.run_last)
    else $error("frame end result is not the last of its request");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("output register overwritten");
`endif

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the box mean filter with zero padding against a behavioral model of
// the window means. A short stimulus table covers reset, register extremes and
// the drain and padding cases. Random frames of small size follow, with noise
// and broken frames, under several idling phases and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmf_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 2'd3;
  localparam int OP_PIXEL = 0;
  localparam int OP_DRAIN = 1;
  localparam int SETTLE = 6000;
  localparam int WATCH_LIMIT = 40000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  in_req_t in_data;
  out_req_t out_data;

  box_mean_filter_zero_pad_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // model state
  logic [7:0] line_mem [MAX_SIDE_DEF*MAX_WIDTH_DEF];
  logic [10:0] width_reg, height_reg;
  logic [4:0] side_reg;
  int pos_row, pos_col;
  out_req_t mean_q [$];

  int errors, items_sent, results_seen, frames_done, quiet_cycles;
  int in_idle_pct, out_idle_pct, hold_cycles;

  typedef struct {
    bit is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit op;
    logic [7:0] pix;
    bit chk;
    out_req_t want;
  } stim_row_t;
  stim_row_t stim_tab [$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    return v > hi ? hi : v;
  endfunction

  task automatic apply_cfg_model(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WIDTH: width_reg = d;
      CFG_HEIGHT: height_reg = d;
      CFG_SIDE: side_reg = d[4:0];
      default: return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  function automatic int pixel_val(int r, int c, int h, int w);
    if (r >= h || c >= w) return 0;
    return line_mem[(r % MAX_SIDE_DEF) * MAX_WIDTH_DEF + c];
  endfunction

  task automatic predict_window(bit op, logic [7:0] pix, output out_req_t res [$]);
    int w, h, s, r, c, lastc, orow, ocol, sum;
    out_req_t o;
    w = clamp_reg(width_reg, MAX_WIDTH_DEF);
    h = clamp_reg(height_reg, MAX_HEIGHT_DEF);
    s = clamp_reg(side_reg, MAX_SIDE_DEF);
    res = {};
    if (pos_row >= h + s - 1 || pos_col >= w) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    if (r < h) line_mem[(r % MAX_SIDE_DEF) * MAX_WIDTH_DEF + c] = op ? 8'd0 : pix;
    if (r >= s - 1) begin
      orow = r - (s - 1);
      lastc = (c == w - 1) ? (w + s - 2) : c;
      for (int cc = c; cc <= lastc; cc++) begin
        if (cc < s - 1) continue;
        ocol = cc - (s - 1);
        sum = 0;
        for (int i = 0; i < s; i++)
          for (int j = 0; j < s; j++)
            sum += pixel_val(orow + i, ocol + j, h, w);
        o.mean_out = 8'(sum / (s * s));
        o.out_row = 10'(orow);
        o.out_column = 10'(ocol);
        o.run_last = 1'b0;
        o.frame_last = (orow == h - 1 && ocol == w - 1);
        res.push_back(o);
      end
      if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h + s - 1) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endtask

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        out_req_t w;
        w = mean_q.pop_front();
        if (out_data.mean_out !== w.mean_out) report("mean_out", out_data.mean_out, w.mean_out);
        if (out_data.out_row !== w.out_row) report("out_row", out_data.out_row, w.out_row);
        if (out_data.out_column !== w.out_column)
          report("out_column", out_data.out_column, w.out_column);
        if (out_data.run_last !== w.run_last) report("run_last", out_data.run_last, w.run_last);
        if (out_data.frame_last !== w.frame_last)
          report("frame_last", out_data.frame_last, w.frame_last);
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", mean_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (mean_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg_model(idx, d);
    @(negedge clk);
    cfg_valid = 0;
    cfg_data = CFG_DATA_W'($urandom);
  endtask

  // drive one pixel request; returns at the negedge after acceptance
  task automatic send_req(bit op, logic [7:0] pix, bit chk, out_req_t want);
    out_req_t res [$];
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data.opcode = op;
    in_data.pixel_in = pix;
    do @(posedge clk); while (!in_ready);
    predict_window(op, pix, res);
    if (chk && (res.size() != 1 || res[0] !== want)) report("table row", res.size(), 1);
    foreach (res[k]) mean_q.push_back(res[k]);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic out_req_t mk(int m, int r, int c, int f);
    out_req_t o;
    o.mean_out = 8'(m);
    o.out_row = 10'(r);
    o.out_column = 10'(c);
    o.run_last = 1'b1;
    o.frame_last = 1'(f);
    return o;
  endfunction

  task automatic add_cfg(logic [CFG_INDEX_W-1:0] idx, int d);
    stim_tab.push_back('{1, idx, CFG_DATA_W'(d), 0, 0, 0, '0});
  endtask

  task automatic add_px(int op, int pix, bit chk, out_req_t want);
    stim_tab.push_back('{0, CFG_NONE, 0, 1'(op), 8'(pix), chk, want});
  endtask

  task automatic run_frame(bit noisy);
    int w, h, s, n, cut;
    w = $urandom_range(12, 1);
    h = $urandom_range(8, 1);
    case ($urandom_range(9))
      0: s = 16;
      1: s = $urandom_range(16, 1);
      default: s = $urandom_range(4, 1);
    endcase
    if (s > 6) h = $urandom_range(2, 1);
    write_cfg(CFG_WIDTH, CFG_DATA_W'(w));
    write_cfg(CFG_HEIGHT, CFG_DATA_W'(h));
    write_cfg(CFG_SIDE, CFG_DATA_W'(s));
    n = h * w + (s - 1) * w;
    cut = ($urandom_range(9) == 0) ? $urandom_range(n, 1) : n;
    for (int i = 0; i < cut; i++) begin
      bit op;
      logic [7:0] pix;
      op = 1'((i >= h * w) ? OP_DRAIN : OP_PIXEL);
      if (noisy && $urandom_range(9) == 0) op = 1'($urandom_range(1));
      case ($urandom_range(5))
        0: pix = 8'hFF;
        1: pix = 8'h00;
        default: pix = 8'($urandom);
      endcase
      send_req(op, pix, 0, '0);
    end
    in_valid = 0;
    frames_done++;
    wait_drained();
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_index = CFG_WIDTH;
    cfg_data = 0;
    in_valid = 0;
    in_data = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    frames_done = 0;
    quiet_cycles = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 0;
    foreach (line_mem[k]) line_mem[k] = 0;
    width_reg = 11'(WIDTH_RST);
    height_reg = 11'(HEIGHT_RST);
    side_reg = 5'(SIDE_RST);
    pos_row = 0;
    pos_col = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed table
    add_px(OP_PIXEL, 8'h11, 0, '0);
    add_cfg(CFG_WIDTH, 2);
    add_cfg(CFG_HEIGHT, 2);
    add_cfg(CFG_SIDE, 1);
    add_px(OP_PIXEL, 255, 1, mk(255, 0, 0, 0));
    add_px(OP_PIXEL, 0, 1, mk(0, 0, 1, 0));
    add_px(OP_DRAIN, 8'hAA, 1, mk(0, 1, 0, 0));
    add_px(OP_PIXEL, 128, 1, mk(128, 1, 1, 1));
    add_cfg(CFG_SIDE, 2);
    add_px(OP_PIXEL, 255, 0, '0);
    add_px(OP_PIXEL, 255, 0, '0);
    add_px(OP_PIXEL, 255, 0, '0);
    add_px(OP_PIXEL, 1, 0, '0);
    add_px(OP_DRAIN, 0, 0, '0);
    add_px(OP_DRAIN, 0, 0, '0);
    add_cfg(CFG_WIDTH, 0);
    add_cfg(CFG_HEIGHT, 0);
    add_cfg(CFG_SIDE, 0);
    add_px(OP_PIXEL, 77, 1, mk(77, 0, 0, 1));
    add_cfg(CFG_SIDE, 2);
    add_px(OP_PIXEL, 200, 0, '0);
    add_px(OP_PIXEL, 99, 1, mk(50, 0, 0, 1));
    add_cfg(CFG_NONE, 5);
    add_cfg(CFG_WIDTH, 2047);
    add_cfg(CFG_HEIGHT, 1);
    add_cfg(CFG_SIDE, 31);
    add_px(OP_PIXEL, 255, 0, '0);
    add_cfg(CFG_WIDTH, 3);
    add_cfg(CFG_HEIGHT, 2047);
    add_cfg(CFG_SIDE, 16);
    add_px(OP_PIXEL, 255, 0, '0);
    add_px(OP_PIXEL, 255, 0, '0);
    add_px(OP_PIXEL, 255, 0, '0);
    foreach (stim_tab[k]) begin
      if (stim_tab[k].is_cfg) begin
        in_valid = 0;
        wait_drained();
        write_cfg(stim_tab[k].idx, stim_tab[k].data);
      end else begin
        send_req(stim_tab[k].op, stim_tab[k].pix, stim_tab[k].chk, stim_tab[k].want);
      end
    end
    in_valid = 0;
    wait_drained();

    // random frames over idling phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0; out_idle_pct = 0; end
        1: begin in_idle_pct = 48; out_idle_pct = 0; end
        2: begin in_idle_pct = 0; out_idle_pct = 48; end
        3: begin in_idle_pct = 26; out_idle_pct = 26; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; hold_cycles = 3000; end
      endcase
      while (items_sent < 30 + (ph + 1) * 100) run_frame(ph != 0);
    end

    // every accepted request is in; frames drained above
    in_valid = 0;
    wait_drained();
    $display("covered %0d requests in %0d random frames, %0d results checked",
             items_sent, frames_done, results_seen);
    $display("register extremes, drain and padding cases, idling phases and a long stall");
    if (errors == 0 && mean_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
